FILE: rtl/auspl_pkg.sv
// ----------------------------------------------------------------------------
// auspl_pkg
// Shared types and constants of the access unit splitter.
// ----------------------------------------------------------------------------
package auspl_pkg;

    localparam int BYTE_W     = 8;
    localparam int NAL_W      = 5;
    localparam int MASK_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DEPTH      = 4;
    localparam int FILL_W     = 3;

    localparam logic [CFG_IDX_W-1:0] REG_INTRA_TYPE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLOSING_TYPE    = 2'd1;

    localparam logic [MASK_W-1:0] INTRA_TYPE_MASK_RST = 32'd160;
    localparam logic [NAL_W-1:0]  CLOSING_TYPE_RST    = 5'd1;

    localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_ONE  = 8'h01;

    typedef struct packed {
        logic              intra;
        logic              start;
        logic              in_frame;
        logic [BYTE_W-1:0] data;
    } entry_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
        logic              start;
        logic              intra;
    } result_t;

endpackage

FILE: rtl/auspl_core.sv
// ----------------------------------------------------------------------------
// auspl_core
// Four-entry byte window with start code detection, frame classification
// and emission of the oldest entry.
// ----------------------------------------------------------------------------
module auspl_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  logic [auspl_pkg::BYTE_W-1:0]  stream_byte,
    input  logic [auspl_pkg::MASK_W-1:0]  intra_type_mask,
    input  logic [auspl_pkg::NAL_W-1:0]   closing_type,
    output auspl_pkg::result_t            result
);

    auspl_pkg::entry_t              pend_reg [auspl_pkg::DEPTH];
    auspl_pkg::entry_t              pend_next [auspl_pkg::DEPTH];
    auspl_pkg::entry_t              mod_entry [auspl_pkg::DEPTH];
    logic [auspl_pkg::FILL_W-1:0]   fill_reg;
    logic [auspl_pkg::FILL_W-1:0]   fill_next;
    logic                           inside_reg;
    logic                           inside_next;
    logic                           intra_reg;
    logic                           intra_next;
    logic [auspl_pkg::NAL_W-1:0]    nal;
    logic                           detect;
    logic                           four_byte;
    logic                           boundary;
    logic                           intra_new;
    logic                           open_frame;
    logic [1:0]                     first_idx;

    always_comb
    begin
        nal       = stream_byte[auspl_pkg::NAL_W-1:0];
        detect    = (fill_reg >= 3'd3) && (pend_reg[0].data == auspl_pkg::BYTE_ONE)
                    && (pend_reg[1].data == auspl_pkg::BYTE_ZERO)
                    && (pend_reg[2].data == auspl_pkg::BYTE_ZERO);
        four_byte = (fill_reg >= 3'd4) && (pend_reg[3].data == auspl_pkg::BYTE_ZERO);
        first_idx = four_byte ? 2'd3 : 2'd2;
        boundary  = !inside_reg || !intra_reg || (nal == closing_type);
        intra_new = intra_type_mask[nal];
        open_frame = detect && boundary;

        for (int k = 0; k < auspl_pkg::DEPTH; k++)
        begin
            mod_entry[k] = pend_reg[k];
            if (open_frame && (2'(k) <= first_idx))
            begin
                mod_entry[k].in_frame = 1'b1;
                mod_entry[k].intra    = intra_new;
                mod_entry[k].start    = (2'(k) == first_idx);
            end
        end

        inside_next = open_frame ? 1'b1 : inside_reg;
        intra_next  = open_frame ? intra_new : intra_reg;

        result.valid = (fill_reg >= 3'd4) && mod_entry[3].in_frame;
        result.data  = mod_entry[3].data;
        result.start = mod_entry[3].start;
        result.intra = mod_entry[3].intra;

        pend_next[0].data     = stream_byte;
        pend_next[0].in_frame = inside_next;
        pend_next[0].intra    = inside_next && intra_next;
        pend_next[0].start    = 1'b0;
        for (int k = 1; k < auspl_pkg::DEPTH; k++)
        begin
            pend_next[k] = mod_entry[k-1];
        end

        fill_next = (fill_reg < 3'd4) ? fill_reg + 3'd1 : fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < auspl_pkg::DEPTH; k++)
            begin
                pend_reg[k] <= '0;
            end
            fill_reg   <= '0;
            inside_reg <= 1'b0;
            intra_reg  <= 1'b0;
        end
        else if (step)
        begin
            for (int k = 0; k < auspl_pkg::DEPTH; k++)
            begin
                pend_reg[k] <= pend_next[k];
            end
            fill_reg   <= fill_next;
            inside_reg <= inside_next;
            intra_reg  <= intra_next;
        end
    end

endmodule

FILE: rtl/h264_access_unit_splitter_top.sv
// ----------------------------------------------------------------------------
// h264_access_unit_splitter_top
// Splits an Annex B byte stream into frames, one byte item per cycle.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle, unless a held result stalls the window.
// An accepted item is held in the input register; when it advances into the
// window, the byte it releases (the one four items older) enters the output
// register. Reset clears the window, the frame state and the handshake flags,
// and loads the register defaults.
module h264_access_unit_splitter_top
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [auspl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [auspl_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [auspl_pkg::BYTE_W-1:0]      stream_byte,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [auspl_pkg::BYTE_W-1:0]      frame_byte,
    output logic                              frame_start,
    output logic                              frame_is_intra
);

    logic [auspl_pkg::MASK_W-1:0]  mask_reg;
    logic [auspl_pkg::NAL_W-1:0]   closing_reg;
    logic                          s1_valid_reg;
    logic                          s1_valid_next;
    logic [auspl_pkg::BYTE_W-1:0]  s1_byte_reg;
    logic                          s1_advance;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [auspl_pkg::BYTE_W-1:0]  out_byte_reg;
    logic                          out_start_reg;
    logic                          out_intra_reg;
    auspl_pkg::result_t            res;

    auspl_core u_core
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step            (s1_advance),
        .stream_byte     (s1_byte_reg),
        .intra_type_mask (mask_reg),
        .closing_type    (closing_reg),
        .result          (res)
    );

    always_comb
    begin
        s1_advance     = s1_valid_reg && (!out_valid_reg || out_ready || !res.valid);
        in_ready       = !s1_valid_reg || s1_advance;
        s1_valid_next  = (in_valid && in_ready) || (s1_valid_reg && !s1_advance);
        out_valid_next = (s1_advance && res.valid) || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= auspl_pkg::INTRA_TYPE_MASK_RST;
            closing_reg   <= auspl_pkg::CLOSING_TYPE_RST;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we && (cfg_index == auspl_pkg::REG_INTRA_TYPE_MASK))
            begin
                mask_reg <= cfg_data;
            end
            if (cfg_we && (cfg_index == auspl_pkg::REG_CLOSING_TYPE))
            begin
                closing_reg <= cfg_data[auspl_pkg::NAL_W-1:0];
            end
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_byte_reg <= stream_byte;
        end
        if (s1_advance && res.valid)
        begin
            out_byte_reg  <= res.data;
            out_start_reg <= res.start;
            out_intra_reg <= res.intra;
        end
    end

    assign out_valid      = out_valid_reg;
    assign frame_byte     = out_byte_reg;
    assign frame_start    = out_start_reg;
    assign frame_is_intra = out_intra_reg;

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        !(s1_advance && res.valid && out_valid_reg && !out_ready))
        else $error("Result register overwritten while still held.");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> s1_valid_reg)
        else $error("Accepted item did not reach the input register.");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("Input stalled with an empty input register.");
`endif

endmodule
